FILE: sv/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants of the token repetition detector
// Word formats, register map, mode codes and fixed thresholds.
// ----------------------------------------------------------------------------
package trd_pkg;

  // token identifier width
  localparam int TOKEN_WIDTH = 18;

  // repetition counter width and its saturation value
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // fill levels at which the checks start
  localparam int MIN_FILL     = 6;
  localparam int RUN_MIN_FILL = 10;
  localparam int COPIES       = 3;

  // mode codes
  localparam logic [1:0] MODE_TOKEN = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // register map (byte address 4*index)
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_INTERVAL  = 2'd2;

  // reset values of the registers
  localparam logic        ENABLE_RST    = 1'b1;
  localparam logic [15:0] THRESHOLD_RST = 16'd5;
  localparam logic [15:0] INTERVAL_RST  = 16'd30;

  typedef struct packed {
    logic [1:0]             mode;
    logic [TOKEN_WIDTH-1:0] token;
    logic [31:0]            now_seconds;
  } in_word_t;

  typedef struct packed {
    logic             detected;
    logic             clear_cache;
    logic             emergency;
    logic [CNT_W-1:0] repetition_total;
  } out_word_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] repeat_threshold;
    logic [15:0] clear_interval;
  } cfg_t;

endpackage

FILE: sv/token_repetition_detector.sv
// ----------------------------------------------------------------------------
// token_repetition_detector: token stream repetition watcher
// Input register, single-pass detection core and output register.
// ----------------------------------------------------------------------------
// One word is accepted per clock cycle while the output is not stalled. A word
// sits in the input register while the core computes its result, and the result
// word is captured in the output register once that register is free or being
// taken. The one-word-per-cycle rate is set by the state update in the core,
// where the tap line, the fill, run and repetition counters and the emergency
// flag are all rewritten at the edge that registers the result. Results hold
// until taken; a stalled output stops the pipeline while the input register
// keeps the next word. Configuration is written through the APB-style port;
// the user must write it only while the block is idle, which the block itself
// does not enforce. Registers sit at byte addresses 0, 4 and 8.
module token_repetition_detector #(
  parameter int WINDOW_DEPTH = 50,
  parameter int MAX_PERIOD   = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  trd_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output trd_pkg::out_word_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [trd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import trd_pkg::*;

  cfg_t      cfg;
  in_word_t  s1_data_r;
  logic      s1_v_r, s1_v_nxt;
  out_word_t out_data_r;
  out_word_t core_res;
  logic      out_v_r, out_v_nxt;
  logic      adv;
  logic      fire;
  logic      in_acc;

  trd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trd_core #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_PERIOD   (MAX_PERIOD)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .word   (s1_data_r),
    .cfg    (cfg),
    .result (core_res)
  );

  // pipeline handshake
  assign adv      = !out_v_r || out_ready;
  assign fire     = s1_v_r && adv;
  assign in_ready = !s1_v_r || adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_v_nxt  = in_acc ? 1'b1 : (fire ? 1'b0 : s1_v_r);
    out_v_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) s1_data_r <= in_data;
    if (fire)   out_data_r <= core_res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // a shown result never reports a detection and a cache clear together
  a_det_xor_clr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.detected && out_data.clear_cache))
    else $error("detection and cache clear in one word");

  // a stalled result keeps the input side from overrunning the pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline full");

  // every processed word shows up at the output next cycle
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r) else $error("processed word lost");

endmodule

FILE: sv/trd_regs.sv
// ----------------------------------------------------------------------------
// trd_regs: configuration registers
// APB-style slave holding enable, repeat threshold and clear interval.
// ----------------------------------------------------------------------------
module trd_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [trd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output trd_pkg::cfg_t              cfg
);
  import trd_pkg::*;

  logic        enable_r, enable_nxt;
  logic [15:0] thr_r, thr_nxt;
  logic [15:0] intv_r, intv_nxt;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // write decode
  always_comb begin
    enable_nxt = enable_r;
    thr_nxt    = thr_r;
    intv_nxt   = intv_r;
    if (wr_en) begin
      case (reg_idx)
        REG_ENABLE:    enable_nxt = pwdata[0];
        REG_THRESHOLD: thr_nxt    = pwdata[15:0];
        REG_INTERVAL:  intv_nxt   = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= ENABLE_RST;
      thr_r    <= THRESHOLD_RST;
      intv_r   <= INTERVAL_RST;
    end else begin
      enable_r <= enable_nxt;
      thr_r    <= thr_nxt;
      intv_r   <= intv_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_ENABLE:    prdata = {31'd0, enable_r};
      REG_THRESHOLD: prdata = {16'd0, thr_r};
      REG_INTERVAL:  prdata = {16'd0, intv_r};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg = '{enable: enable_r, repeat_threshold: thr_r, clear_interval: intv_r};

endmodule

FILE: sv/trd_core.sv
// ----------------------------------------------------------------------------
// trd_core: detection state and single-pass update
// Tap line of the newest tokens, fill and run counters, repetition counter,
// emergency flag and detection time; computes the result of one word.
// ----------------------------------------------------------------------------
module trd_core #(
  parameter int WINDOW_DEPTH = 50,
  parameter int MAX_PERIOD   = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  trd_pkg::in_word_t   word,
  input  trd_pkg::cfg_t       cfg,
  output trd_pkg::out_word_t  result
);
  import trd_pkg::*;

  // only the newest taps are ever compared; older entries just count as fill
  localparam int NTAP = COPIES * MAX_PERIOD;
  localparam int FW   = $clog2(WINDOW_DEPTH + 1);

  logic [TOKEN_WIDTH-1:0] taps_r [NTAP];
  logic [TOKEN_WIDTH-1:0] win_n  [NTAP];
  logic [FW-1:0]          fill_r, fill_nxt, fill_tok;
  logic [FW-1:0]          run_r, run_nxt, run_tok;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt, cnt_tok;
  logic                   emerg_r, emerg_nxt;
  logic [31:0]            last_r, last_nxt;
  logic                   tok_hit;
  logic                   clr;
  logic                   take;
  logic [MAX_PERIOD:2]    match;
  logic [CNT_W:0]         run_sum;
  logic [31:0]            elapsed;

  assign take = (word.mode == MODE_TOKEN) && cfg.enable;

  // window contents after inserting the token
  always_comb begin
    win_n[0] = word.token;
    for (int k = 1; k < NTAP; k++) win_n[k] = taps_r[k-1];
  end

  // fill and run after insertion
  always_comb begin
    fill_tok = (int'(fill_r) >= WINDOW_DEPTH) ? FW'(WINDOW_DEPTH) : fill_r + 1'b1;
    if (fill_r != '0 && taps_r[0] == word.token)
      run_tok = (int'(run_r) < WINDOW_DEPTH) ? run_r + 1'b1 : FW'(WINDOW_DEPTH);
    else
      run_tok = FW'(1);
    if (run_tok > fill_tok) run_tok = fill_tok;
  end

  // period comparators, all in parallel
  always_comb begin
    for (int p = 2; p <= MAX_PERIOD; p++) begin
      match[p] = (int'(fill_tok) >= MIN_FILL) && (int'(fill_tok) >= COPIES * p);
      for (int i = 0; i < p; i++) begin
        if (win_n[i] != win_n[i+p] || win_n[i] != win_n[i+2*p]) match[p] = 1'b0;
      end
    end
  end

  // counter chain over periods in ascending order, then the run check
  always_comb begin
    cnt_tok = cnt_r;
    tok_hit = 1'b0;
    run_sum = '0;
    for (int p = 2; p <= MAX_PERIOD; p++) begin
      if (!tok_hit && match[p]) begin
        if (cnt_tok != CNT_MAX) cnt_tok = cnt_tok + 1'b1;
        if (cnt_tok >= cfg.repeat_threshold) tok_hit = 1'b1;
      end
    end
    if (!tok_hit && int'(fill_tok) >= RUN_MIN_FILL &&
        CNT_W'(run_tok) >= cfg.repeat_threshold) begin
      run_sum = {1'b0, cnt_tok} + (CNT_W+1)'(run_tok);
      cnt_tok = run_sum[CNT_W] ? CNT_MAX : run_sum[CNT_W-1:0];
      tok_hit = 1'b1;
    end
  end

  assign elapsed = word.now_seconds - last_r;

  // next state and result by mode
  always_comb begin
    fill_nxt  = fill_r;
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    emerg_nxt = emerg_r;
    last_nxt  = last_r;
    clr       = 1'b0;
    result.detected = 1'b0;
    case (word.mode)
      MODE_TOKEN: begin
        if (take) begin
          fill_nxt = fill_tok;
          run_nxt  = run_tok;
          cnt_nxt  = cnt_tok;
          if (tok_hit) begin
            emerg_nxt = 1'b1;
            last_nxt  = word.now_seconds;
          end
          result.detected = tok_hit;
        end
      end
      MODE_QUERY: begin
        clr = cfg.enable && emerg_r && (elapsed >= {16'd0, cfg.clear_interval});
      end
      MODE_CLEAR: begin
        fill_nxt  = '0;
        run_nxt   = '0;
        cnt_nxt   = '0;
        emerg_nxt = 1'b0;
        last_nxt  = '0;
      end
      default: ;
    endcase
    result.clear_cache      = clr;
    result.emergency        = emerg_nxt;
    result.repetition_total = cnt_nxt;
  end

  // tap line, no reset needed: reads are guarded by the fill count
  always_ff @(posedge clk) begin
    if (fire && take) begin
      for (int k = 0; k < NTAP; k++) taps_r[k] <= win_n[k];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      run_r   <= '0;
      cnt_r   <= '0;
      emerg_r <= 1'b0;
      last_r  <= '0;
    end else if (fire) begin
      fill_r  <= fill_nxt;
      run_r   <= run_nxt;
      cnt_r   <= cnt_nxt;
      emerg_r <= emerg_nxt;
      last_r  <= last_nxt;
    end
  end

  // run never longer than the fill, fill never past the window depth
  a_run_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    run_r <= fill_r) else $error("run length exceeds fill count");

  a_fill_depth: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= WINDOW_DEPTH) else $error("fill count past window depth");

  // a clear word empties the fill count, the repetition counter and the emergency flag
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && word.mode == MODE_CLEAR |=> fill_r == '0 && cnt_r == '0 && !emerg_r)
    else $error("clear word left state behind");

  // a detection always leaves emergency set
  a_det_emerg: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.detected |=> emerg_r) else $error("detection without emergency");

endmodule

FILE: dv/token_repetition_detector_tb.sv
// ----------------------------------------------------------------------------
// token_repetition_detector_tb: self-checking bench for the repetition watcher
// Drives token, query, clear and unused-mode words through the valid/ready
// input, predicts every result word with a behavioral copy of the window,
// streak and counter logic, and compares each result field by field under
// random idling, a long output stall and several register settings.
// ----------------------------------------------------------------------------
module token_repetition_detector_tb;
  import trd_pkg::*;

  localparam int DEPTH          = 50;
  localparam int LONGEST_PERIOD = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int SAT_TOKENS     = 60;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  token_repetition_detector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // predicted detector state and register copy
  logic [TOKEN_WIDTH-1:0] hist [DEPTH];
  int                     hist_fill;
  int                     streak;
  int                     rep_count;
  bit                     alarm;
  logic [31:0]            alarm_time;
  bit                     cfg_enable;
  int                     cfg_threshold;
  logic [15:0]            cfg_interval;

  out_word_t              expected_words [$];
  int                     errors;
  bit                     feed_steady;
  bit                     sink_steady;
  bit                     hold_request;
  logic [TOKEN_WIDTH-1:0] symbol_pool [6];
  logic [31:0]            clock_now;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic void wipe_history();
    for (int i = 0; i < DEPTH; i++) hist[i] = '0;
    hist_fill  = 0;
    streak     = 0;
    rep_count  = 0;
    alarm      = 1'b0;
    alarm_time = '0;
  endfunction

  // entry k places back from the newest
  function automatic logic [TOKEN_WIDTH-1:0] recent(int k);
    if (k >= hist_fill) return '0;
    return hist[hist_fill - 1 - k];
  endfunction

  function automatic void bump_count(int n);
    rep_count = (rep_count + n > int'(CNT_MAX)) ? int'(CNT_MAX) : rep_count + n;
  endfunction

  function automatic bit absorb_token(logic [TOKEN_WIDTH-1:0] tok, logic [31:0] now);
    bit hit;
    // streak of the newest token
    if (hist_fill > 0 && recent(0) == tok) begin
      streak = (streak < DEPTH) ? streak + 1 : DEPTH;
    end else begin
      streak = 1;
    end
    // shift into the window, oldest drops out when full
    if (hist_fill >= DEPTH) begin
      for (int i = 0; i < DEPTH - 1; i++) hist[i] = hist[i + 1];
      hist[DEPTH - 1] = tok;
    end else begin
      hist[hist_fill] = tok;
      hist_fill++;
    end
    if (streak > hist_fill) streak = hist_fill;
    if (hist_fill < MIN_FILL) return 1'b0;
    // period checks, ascending, first trigger wins
    for (int p = 2; p <= LONGEST_PERIOD; p++) begin
      if (hist_fill >= COPIES * p) begin
        hit = 1'b1;
        for (int i = 0; i < p; i++) begin
          if (recent(i) != recent(i + p) || recent(i) != recent(i + 2 * p)) hit = 1'b0;
        end
        if (hit) begin
          bump_count(1);
          if (rep_count >= cfg_threshold) begin
            alarm      = 1'b1;
            alarm_time = now;
            return 1'b1;
          end
        end
      end
    end
    // long run of one token
    if (hist_fill >= RUN_MIN_FILL && streak >= cfg_threshold) begin
      bump_count(streak);
      alarm      = 1'b1;
      alarm_time = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t   r;
    logic [31:0] elapsed;
    r = '0;
    case (w.mode)
      MODE_TOKEN: begin
        if (cfg_enable) r.detected = absorb_token(w.token, w.now_seconds);
      end
      MODE_QUERY: begin
        elapsed       = w.now_seconds - alarm_time;
        r.clear_cache = cfg_enable && alarm && (elapsed >= {16'd0, cfg_interval});
      end
      MODE_CLEAR: begin
        wipe_history();
      end
      default: ;
    endcase
    r.emergency        = alarm;
    r.repetition_total = rep_count[CNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random ready, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= sink_steady ? 1'b1 : ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word det=%0b clr=%0b emg=%0b total=%0d", $time,
                 out_data.detected, out_data.clear_cache, out_data.emergency,
                 out_data.repetition_total);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (out_data.detected !== want.detected || out_data.clear_cache !== want.clear_cache ||
            out_data.emergency !== want.emergency ||
            out_data.repetition_total !== want.repetition_total) begin
          $display("%0t: mismatch expected det=%0b clr=%0b emg=%0b total=%0d", $time,
                   want.detected, want.clear_cache, want.emergency, want.repetition_total);
          $display("%0t:          actual   det=%0b clr=%0b emg=%0b total=%0d", $time,
                   out_data.detected, out_data.clear_cache, out_data.emergency,
                   out_data.repetition_total);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [1:0] mode, logic [TOKEN_WIDTH-1:0] tok, logic [31:0] now);
    in_word_t w;
    int       gap;
    w.mode        = mode;
    w.token       = tok;
    w.now_seconds = now;
    @(negedge clk);
    // random idle before the word
    if (!feed_steady && $urandom_range(0, 99) < 25) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    expected_words.insert(expected_words.size(), predict_word(w));
  endtask

  function automatic logic [31:0] tick_time();
    clock_now = clock_now + $urandom_range(0, 3);
    return clock_now;
  endfunction

  task automatic send_token(logic [TOKEN_WIDTH-1:0] tok);
    send_word(MODE_TOKEN, tok, tick_time());
  endtask

  // idle input, wait for every result, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ENABLE:    cfg_enable    = value[0];
      REG_THRESHOLD: cfg_threshold = value[15:0];
      REG_INTERVAL:  cfg_interval  = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly a small pool so that repeats happen, sometimes any token
  function automatic logic [TOKEN_WIDTH-1:0] pick_token();
    if ($urandom_range(0, 99) < 70) return symbol_pool[$urandom_range(0, 5)];
    return TOKEN_WIDTH'($urandom);
  endfunction

  // well-formed repeats and runs, with noise, queries and clears
  task automatic random_traffic(int n_words);
    int                     sent;
    int                     kind;
    int                     period;
    int                     copies;
    int                     len;
    logic [TOKEN_WIDTH-1:0] motif [4];
    logic [TOKEN_WIDTH-1:0] tok;
    for (int i = 0; i < 6; i++) symbol_pool[i] = TOKEN_WIDTH'($urandom);
    sent = 0;
    while (sent < n_words) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // repeated motif, occasionally broken
        period = $urandom_range(1, LONGEST_PERIOD);
        for (int i = 0; i < period; i++) motif[i] = pick_token();
        copies = $urandom_range(2, 12);
        for (int c = 0; c < copies; c++) begin
          for (int i = 0; i < period; i++) begin
            tok = ($urandom_range(0, 99) < 8) ? pick_token() : motif[i];
            send_token(tok);
            sent++;
          end
        end
      end else if (kind < 60) begin
        // run of one token, sometimes longer than the window
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH, DEPTH + 6)
                                          : $urandom_range(1, 20);
        tok = pick_token();
        repeat (len) send_token(tok);
        sent += len;
      end else if (kind < 72) begin
        len = $urandom_range(1, 8);
        repeat (len) send_token(TOKEN_WIDTH'($urandom));
        sent += len;
      end else if (kind < 86) begin
        if ($urandom_range(0, 99) < 70) begin
          send_word(MODE_QUERY, TOKEN_WIDTH'($urandom), clock_now + $urandom_range(0, 80));
        end else begin
          send_word(MODE_QUERY, TOKEN_WIDTH'($urandom), $urandom);
        end
        sent++;
      end else if (kind < 92) begin
        send_word(MODE_CLEAR, TOKEN_WIDTH'($urandom), $urandom);
        sent++;
      end else if (kind < 96) begin
        send_word(MODE_UNUSED, TOKEN_WIDTH'($urandom), $urandom);
        sent++;
      end else begin
        // time jump, possibly backwards
        clock_now = $urandom;
        send_word(MODE_QUERY, TOKEN_WIDTH'($urandom), clock_now);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [TOKEN_WIDTH-1:0] top_tok;
    top_tok = '1;
    // query right after reset
    send_word(MODE_QUERY, '0, 32'd0);
    // alternating extremes: period two matches, fifth match triggers
    for (int i = 0; i < 12; i++) begin
      send_word(MODE_TOKEN, (i % 2 == 0) ? top_tok : '0, 32'hFFFF_FFF0);
    end
    // queries across the wrap of the time counter
    send_word(MODE_QUERY, top_tok, 32'd5);
    send_word(MODE_QUERY, '0, 32'd14);
    send_word(MODE_QUERY, top_tok, 32'hFFFF_FFFF);
    // unused mode reports state only
    send_word(MODE_UNUSED, top_tok, 32'hFFFF_FFFF);
    // clear, then confirm state is gone
    send_word(MODE_CLEAR, top_tok, 32'd0);
    send_word(MODE_QUERY, '0, 32'hFFFF_FFFF);
    // one token over and over
    repeat (8) send_word(MODE_TOKEN, 18'h2AAAA, 32'h5555_5555);
  endtask

  task automatic test_backpressure();
    cfg_write(REG_ENABLE, 32'd1);
    cfg_write(REG_THRESHOLD, 32'd5);
    cfg_write(REG_INTERVAL, 32'd30);
    hold_request = 1'b1;
    random_traffic(300);
  endtask

  task automatic test_register_extremes();
    cfg_write(REG_THRESHOLD, 32'd0);
    cfg_write(REG_INTERVAL, 32'd0);
    random_traffic(150);
    cfg_write(REG_THRESHOLD, 32'hFFFF_FFFF);
    cfg_write(REG_INTERVAL, 32'hFFFF_FFFF);
    random_traffic(150);
  endtask

  task automatic test_disabled();
    cfg_write(REG_THRESHOLD, 32'd3);
    cfg_write(REG_INTERVAL, 32'd10);
    cfg_write(REG_ENABLE, 32'd0);
    random_traffic(150);
    cfg_write(REG_ENABLE, 32'd1);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      cfg_write(REG_THRESHOLD, $urandom_range(1, 12));
      cfg_write(REG_INTERVAL, $urandom_range(0, 120));
      random_traffic(100);
    end
  endtask

  task automatic test_steady_flow();
    drain();
    feed_steady = 1'b1;
    sink_steady = 1'b1;
    random_traffic(150);
    drain();
    feed_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  // highest threshold: up to three matches per token, counter climbs with no trigger
  task automatic test_saturation();
    cfg_write(REG_THRESHOLD, 32'h0000_FFFF);
    send_word(MODE_CLEAR, '0, 32'd0);
    repeat (SAT_TOKENS) send_token(18'h1F0F0);
    send_word(MODE_QUERY, '0, clock_now);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    errors       = 0;
    feed_steady  = 1'b0;
    sink_steady  = 1'b0;
    hold_request = 1'b0;
    clock_now    = 32'd1000;
    wipe_history();
    cfg_enable    = ENABLE_RST;
    cfg_threshold = THRESHOLD_RST;
    cfg_interval  = INTERVAL_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_register_extremes();
    test_disabled();
    test_random_settings();
    test_steady_flow();
    test_saturation();

    drain();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
